[hdl/oase_pkg.sv]
package oase_pkg;

  localparam int SET_DEPTH = 64;
  localparam int ADDR_BITS = 16;
  localparam int IDX_W     = $clog2(SET_DEPTH);
  localparam int CNT_W     = $clog2(SET_DEPTH + 1);

  typedef enum logic [3:0] {
    ACT_INSERT    = 4'd0,
    ACT_REMOVE    = 4'd1,
    ACT_LOAD_OP   = 4'd2,
    ACT_CLEAR_OP  = 4'd3,
    ACT_UNION     = 4'd4,
    ACT_INTERSECT = 4'd5,
    ACT_DIFF      = 4'd6,
    ACT_READ      = 4'd7,
    ACT_CLEAR     = 4'd8
  } action_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] address;
    logic [5:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  member_count;
    logic [15:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     waddr;
    logic [ADDR_BITS-1:0] wdata;
    logic [IDX_W-1:0]     raddr;
  } ram_req_t;

endpackage

[hdl/oase_ram.sv]
module oase_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/oase_ctrl.sv]
module oase_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  oase_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output oase_pkg::out_item_t           out_item,
  output oase_pkg::ram_req_t            set_req,
  input  logic [oase_pkg::ADDR_BITS-1:0] set_rdata,
  output oase_pkg::ram_req_t            op_req,
  input  logic [oase_pkg::ADDR_BITS-1:0] op_rdata
);
  import oase_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SC_RD, S_SC_CHK, S_POST, S_SH_RD, S_SH_WR,
    S_U_RD, S_U_GET, S_F_RD, S_F_GET, S_RD_WAIT, S_DONE
  } state_t;

  state_t               state;
  logic [3:0]           act;
  logic [ADDR_BITS-1:0] val;
  logic [CNT_W-1:0]     cnt, opc, i, j, w, orig, limit;
  logic                 sc_op, found;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] rv;

  logic                 full, op_full, keep;
  logic [ADDR_BITS-1:0] sc_data;

  assign full     = (cnt == CNT_W'(SET_DEPTH));
  assign op_full  = (opc == CNT_W'(SET_DEPTH));
  assign keep     = (found == (act == ACT_INTERSECT));
  assign sc_data  = sc_op ? op_rdata : set_rdata;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    set_req = '0;
    op_req  = '0;
    set_req.wdata = val;
    op_req.wdata  = val;
    set_req.raddr = j[IDX_W-1:0];
    op_req.raddr  = j[IDX_W-1:0];
    unique case (state)
      S_SH_RD, S_F_RD: set_req.raddr = i[IDX_W-1:0];
      S_U_RD:          op_req.raddr  = i[IDX_W-1:0];
      S_IDLE:          set_req.raddr = in_item.index[IDX_W-1:0];
      S_SH_WR: begin
        set_req.we    = 1'b1;
        set_req.waddr = IDX_W'(i - 1'b1);
        set_req.wdata = set_rdata;
      end
      S_POST: begin
        unique case (act)
          ACT_INSERT, ACT_UNION: begin
            set_req.we    = !found && !full;
            set_req.waddr = cnt[IDX_W-1:0];
          end
          ACT_INTERSECT, ACT_DIFF: begin
            set_req.we    = keep;
            set_req.waddr = w[IDX_W-1:0];
          end
          ACT_LOAD_OP: begin
            op_req.we    = !found && !op_full;
            op_req.waddr = opc[IDX_W-1:0];
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      opc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            act    <= in_item.action;
            val    <= in_item.address[ADDR_BITS-1:0];
            status <= ST_OK;
            rv     <= '0;
            j      <= '0;
            i      <= '0;
            w      <= '0;
            orig   <= cnt;
            state  <= S_DONE;
            unique case (in_item.action)
              ACT_INSERT, ACT_REMOVE: begin
                sc_op <= 1'b0;
                limit <= cnt;
                state <= S_SC_RD;
              end
              ACT_LOAD_OP: begin
                sc_op <= 1'b1;
                limit <= opc;
                state <= S_SC_RD;
              end
              ACT_CLEAR_OP: opc <= '0;
              ACT_CLEAR:    cnt <= '0;
              ACT_UNION:    state <= S_U_RD;
              ACT_INTERSECT, ACT_DIFF: state <= S_F_RD;
              ACT_READ: begin
                if (CNT_W'(in_item.index) < cnt) begin
                  state <= S_RD_WAIT;
                end else begin
                  status <= ST_ABSENT;
                end
              end
              default: ;
            endcase
          end
        end
        S_SC_RD: begin
          if (j >= limit) begin
            found <= 1'b0;
            state <= S_POST;
          end else begin
            state <= S_SC_CHK;
          end
        end
        S_SC_CHK: begin
          if (sc_data == val) begin
            found <= 1'b1;
            state <= S_POST;
          end else begin
            j     <= j + 1'b1;
            state <= S_SC_RD;
          end
        end
        S_POST: begin
          state <= S_DONE;
          unique case (act)
            ACT_INSERT: begin
              if (found) status <= ST_DUP;
              else if (full) status <= ST_FULL;
              else cnt <= cnt + 1'b1;
            end
            ACT_LOAD_OP: begin
              if (found) status <= ST_DUP;
              else if (op_full) status <= ST_FULL;
              else opc <= opc + 1'b1;
            end
            ACT_REMOVE: begin
              if (!found) begin
                status <= ST_ABSENT;
              end else begin
                i     <= j + 1'b1;
                state <= S_SH_RD;
              end
            end
            ACT_UNION: begin
              if (!found) begin
                if (full) status <= ST_FULL;
                else cnt <= cnt + 1'b1;
              end
              i     <= i + 1'b1;
              state <= S_U_RD;
            end
            ACT_INTERSECT, ACT_DIFF: begin
              if (keep) w <= w + 1'b1;
              i     <= i + 1'b1;
              state <= S_F_RD;
            end
            default: ;
          endcase
        end
        S_SH_RD: begin
          if (i >= cnt) begin
            cnt   <= cnt - 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          i     <= i + 1'b1;
          state <= S_SH_RD;
        end
        S_U_RD: begin
          state <= (i >= opc) ? S_DONE : S_U_GET;
        end
        S_U_GET: begin
          val   <= op_rdata;
          j     <= '0;
          sc_op <= 1'b0;
          limit <= orig;
          state <= S_SC_RD;
        end
        S_F_RD: begin
          if (i >= cnt) begin
            cnt   <= w;
            state <= S_DONE;
          end else begin
            state <= S_F_GET;
          end
        end
        S_F_GET: begin
          val   <= set_rdata;
          j     <= '0;
          sc_op <= 1'b1;
          limit <= opc;
          state <= S_SC_RD;
        end
        S_RD_WAIT: begin
          rv    <= set_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid             <= 1'b1;
          out_item.status       <= status;
          out_item.member_count <= 7'(cnt);
          out_item.read_value   <= 16'(rv);
          state                 <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/ordered_address_set_engine.sv]
// Ordered address set engine.
// Input channel in_valid/in_ready/in_item carries one action (insert, remove,
// load operand, clear operand, union, intersect, difference, read, clear).
// Output channel out_valid/out_ready/out_item returns exactly one result per
// action: status, destination member count and read value.
// One action is in flight at a time. Each stored entry that is visited is
// read on the single read port of a RAM: address, then compare.
// Insert, remove and load scan the target set for a match; remove then shifts
// later entries down. Intersect and difference scan the operand per destination
// entry, union scans the destination per operand entry. Read fetches one
// entry; clears, out-of-range reads and unused codes do not visit the RAM.
// A new action is taken once the previous one finishes and its result is
// taken or is being taken in the same cycle. A stalled receiver holds the
// result in the output register and the block waits.
// Reset (rst, synchronous) empties both sets by clearing their counts; RAM
// contents are not cleared, entries past the counts are never read.
module ordered_address_set_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  oase_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output oase_pkg::out_item_t out_item
);
  import oase_pkg::*;

  ram_req_t             set_req, op_req;
  logic [ADDR_BITS-1:0] set_rdata, op_rdata;

  oase_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .out_valid, .out_ready, .out_item,
    .set_req, .set_rdata, .op_req, .op_rdata
  );

  oase_ram #(.WIDTH(ADDR_BITS), .DEPTH(SET_DEPTH)) u_set_ram (
    .clk, .we(set_req.we), .waddr(set_req.waddr), .wdata(set_req.wdata),
    .raddr(set_req.raddr), .rdata(set_rdata)
  );

  oase_ram #(.WIDTH(ADDR_BITS), .DEPTH(SET_DEPTH)) u_op_ram (
    .clk, .we(op_req.we), .waddr(op_req.waddr), .wdata(op_req.wdata),
    .raddr(op_req.raddr), .rdata(op_rdata)
  );

endmodule

[hdl/oase_checker.sv]
module oase_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input oase_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input oase_pkg::out_item_t out_item
);
  import oase_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_item))
    else $error("input dropped before transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.member_count <= 7'(SET_DEPTH))
    else $error("member count beyond depth");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind ordered_address_set_engine oase_checker u_oase_checker (
  .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item
);
